// File: sv/smrc_pkg.sv
// Shared types, codes and reset values for the stepper move ramp controller.
package smrc_pkg;

  localparam int unsigned PULSE_DUTY_DIV_DEF = 2;

  localparam int unsigned POS_W    = 16;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned RAMP_W   = 8;
  localparam int unsigned TORQUE_W = 8;
  localparam int unsigned CFG_W    = 16;

  localparam logic [POS_W-1:0]    MAX_TRAVEL_RST    = 16'd4000;
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST  = 16'd1000;
  localparam logic [PERIOD_W-1:0] CRUISE_PERIOD_RST = 16'd200;
  localparam logic [RAMP_W-1:0]   RAMP_STEP_RST     = 8'd5;

  // Driver torque code is 150 * percent / 100.
  localparam int unsigned TORQUE_FULL   = 150;
  localparam logic [TORQUE_W-1:0] TORQUE_MOVING = TORQUE_W'((TORQUE_FULL * 90) / 100);
  localparam logic [TORQUE_W-1:0] TORQUE_IDLE   = TORQUE_W'((TORQUE_FULL * 10) / 100);

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_MOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ENDSTOP = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_MAX_TRAVEL    = 2'd0,
    CFG_START_PERIOD  = 2'd1,
    CFG_CRUISE_PERIOD = 2'd2,
    CFG_RAMP_STEP     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [TORQUE_W-1:0] torque_code;
    logic [POS_W-1:0]    position;
    status_t             status;
    logic                done_res;
    logic                busy_res;
    logic                dir_out;
    logic                step_out;
  } result_t;

endpackage

// File: sv/stepper_move_ramp_controller_core.sv
// Stepper move controller with a linear start ramp, one result per request.
//
// Input channel: each request is a time tick (tuser = 0) or a move command
// (tuser = 1) carrying a target position and the endstop level. Every
// accepted request yields exactly one result on the output channel: step
// pulse, direction, busy, done, status, position and driver torque code.
// The configuration port writes max travel, start period, cruise period and ramp
// step; the user must write it only while no result is outstanding (not enforced).
//
// The move state and the result register are both updated at the edge that
// accepts the request. Throughput is one request per cycle while the receiver
// keeps up, set by the single result register. A request is taken whenever
// the result register is empty or being drained in the same cycle, so a
// stalled receiver holds the result and back-pressures the input.
//
// Reset clears the move state and position, loads the default configuration
// and empties the result register.
module stepper_move_ramp_controller_core
  import smrc_pkg::*;
#(
  parameter int unsigned PULSE_DUTY_DIV = PULSE_DUTY_DIV_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // target[15:0], endstop_level[16], zero fill
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // step_out, dir_out, busy_res, done_res, status[1:0],
                                  // position[15:0], torque_code[7:0], zero fill
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned DUTY_W = $clog2(PULSE_DUTY_DIV + 1);
  localparam int unsigned PROD_W = PERIOD_W + 1 + DUTY_W;

  // Configuration registers.
  logic [POS_W-1:0]    max_travel_r;
  logic [PERIOD_W-1:0] start_period_r;
  logic [PERIOD_W-1:0] cruise_period_r;
  logic [RAMP_W-1:0]   ramp_step_r;

  // Move state.
  logic [POS_W-1:0]    cur_position_r,  cur_position_nxt;
  logic [POS_W-1:0]    steps_left_r,    steps_left_nxt;
  logic [PERIOD_W-1:0] step_period_r,   step_period_nxt;
  logic [PERIOD_W-1:0] phase_count_r,   phase_count_nxt;
  logic [POS_W-1:0]    goal_position_r, goal_position_nxt;
  logic                move_dir_r,      move_dir_nxt;
  logic                moving_r,        moving_nxt;

  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic                in_fire;
  func_t               func;
  logic [POS_W-1:0]    target;
  logic                endstop_hit;
  logic [PERIOD_W-1:0] per;
  logic [PERIOD_W:0]   phase_inc;
  logic [PROD_W-1:0]   phase_scaled;
  logic                pulse_high;
  logic [PERIOD_W-1:0] per_ramped;
  logic [POS_W-1:0]    distance;
  logic                step;
  logic                done;
  status_t             status;

  assign in_tready   = !out_valid_r || out_tready;
  assign in_fire     = in_tvalid && in_tready;
  assign func        = func_t'(in_tuser);
  assign target      = in_tdata[POS_W-1:0];
  assign endstop_hit = !in_tdata[POS_W];

  assign per          = (step_period_r != '0) ? step_period_r : PERIOD_W'(1);
  assign phase_inc    = {1'b0, phase_count_r} + (PERIOD_W+1)'(1);
  // phase < max(1, per / DIV) is the same as phase == 0 or (phase + 1) * DIV <= per.
  assign phase_scaled = PROD_W'(phase_inc) * PROD_W'(PULSE_DUTY_DIV);
  assign pulse_high   = (phase_count_r == '0) || (phase_scaled <= PROD_W'(per));
  assign per_ramped   = (per > cruise_period_r)
                        ? ((per > PERIOD_W'(ramp_step_r)) ? per - PERIOD_W'(ramp_step_r)
                                                          : PERIOD_W'(1))
                        : per;
  assign distance     = (cur_position_r > target) ? cur_position_r - target
                                                  : target - cur_position_r;

  always_comb begin
    cur_position_nxt  = cur_position_r;
    steps_left_nxt    = steps_left_r;
    step_period_nxt   = step_period_r;
    phase_count_nxt   = phase_count_r;
    goal_position_nxt = goal_position_r;
    move_dir_nxt      = move_dir_r;
    moving_nxt        = moving_r;
    step              = 1'b0;
    done              = 1'b0;
    status            = ST_OK;

    if (func == FUNC_MOVE) begin
      // A command that arrives during a move is dropped.
      if (!moving_r) begin
        if (target > max_travel_r) begin
          done   = 1'b1;
          status = ST_RANGE;
        end else begin
          move_dir_nxt      = cur_position_r > target;
          step_period_nxt   = (start_period_r != '0) ? start_period_r : PERIOD_W'(1);
          phase_count_nxt   = '0;
          goal_position_nxt = target;
          if (distance == '0) begin
            steps_left_nxt   = '0;
            cur_position_nxt = target;
            done             = 1'b1;
            status           = endstop_hit ? ST_ENDSTOP : ST_OK;
          end else begin
            steps_left_nxt = distance;
            moving_nxt     = 1'b1;
          end
        end
      end
    end else if (moving_r) begin
      if (endstop_hit) begin
        moving_nxt       = 1'b0;
        steps_left_nxt   = '0;
        phase_count_nxt  = '0;
        cur_position_nxt = goal_position_r;
        done             = 1'b1;
        status           = ST_ENDSTOP;
      end else begin
        step            = pulse_high;
        phase_count_nxt = phase_inc[PERIOD_W-1:0];
        if (phase_inc >= {1'b0, per}) begin
          phase_count_nxt = '0;
          steps_left_nxt  = steps_left_r - POS_W'(1);
          step_period_nxt = per_ramped;
          if (steps_left_r == POS_W'(1)) begin
            moving_nxt       = 1'b0;
            steps_left_nxt   = '0;
            cur_position_nxt = goal_position_r;
            done             = 1'b1;
          end
        end
      end
    end

    res_nxt.step_out    = step;
    res_nxt.dir_out     = move_dir_nxt;
    res_nxt.busy_res    = moving_nxt;
    res_nxt.done_res    = done;
    res_nxt.status      = status;
    res_nxt.position    = cur_position_nxt;
    res_nxt.torque_code = moving_nxt ? TORQUE_MOVING : TORQUE_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_travel_r    <= MAX_TRAVEL_RST;
      start_period_r  <= START_PERIOD_RST;
      cruise_period_r <= CRUISE_PERIOD_RST;
      ramp_step_r     <= RAMP_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MAX_TRAVEL:    max_travel_r    <= cfg_wdata;
        CFG_START_PERIOD:  start_period_r  <= cfg_wdata;
        CFG_CRUISE_PERIOD: cruise_period_r <= cfg_wdata;
        CFG_RAMP_STEP:     ramp_step_r     <= cfg_wdata[RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_position_r  <= '0;
      steps_left_r    <= '0;
      step_period_r   <= '0;
      phase_count_r   <= '0;
      goal_position_r <= '0;
      move_dir_r      <= 1'b0;
      moving_r        <= 1'b0;
    end else if (in_fire) begin
      cur_position_r  <= cur_position_nxt;
      steps_left_r    <= steps_left_nxt;
      step_period_r   <= step_period_nxt;
      phase_count_r   <= phase_count_nxt;
      goal_position_r <= goal_position_nxt;
      move_dir_r      <= move_dir_nxt;
      moving_r        <= moving_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

  // A running move always has steps to go and a nonzero period.
  a_moving_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (steps_left_r != '0) && (step_period_r != '0))
    else $error("move running with no steps left or zero period");

  // The phase counter stays inside the current period.
  a_phase_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    moving_r |-> (phase_count_r < step_period_r))
    else $error("phase counter outside step period");

  // A finished move leaves the block idle, with a valid result that is not busy.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_nxt.done_res) |=> !moving_r && out_valid_r && !res_r.busy_res)
    else $error("move finished but block still busy");

  // The reported busy flag and position follow the move state.
  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (res_r.busy_res == moving_r) && (res_r.position == cur_position_r))
    else $error("result does not match move state");

endmodule
